FILE: sv/afw_pkg.sv
// ----------------------------------------------------------------------------
// afw_pkg: shared types and constants of the audio prefetch ring
// Word layouts, operation and result codes, controller/datapath bundles.
// ----------------------------------------------------------------------------
package afw_pkg;

  localparam int RING_DEPTH  = 16384;  // power of two
  localparam int PTR_W       = $clog2(RING_DEPTH);
  localparam int AVAIL_W     = PTR_W + 1;
  localparam int FADE_MAX    = 64;
  localparam int MAX_REQUEST = 64;
  localparam int REQ_W       = 7;
  localparam int THR_W       = 15;
  localparam int SMP_W       = 16;
  localparam int CNT_W       = 48;
  localparam int FRAME_W     = 2 * SMP_W;
  localparam int MUL_W       = SMP_W + REQ_W + 1;
  localparam int MAG_W       = 21;
  localparam int STEP_W      = $clog2(MAG_W);

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(4096);

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_PULL  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic [1:0] KIND_FRAME     = 2'd0;
  localparam logic [1:0] KIND_PUSH_OK   = 2'd1;
  localparam logic [1:0] KIND_PUSH_FULL = 2'd2;
  localparam logic [1:0] KIND_EOS       = 2'd3;

  typedef struct packed {
    logic [1:0]             operation;
    logic signed [SMP_W-1:0] left_in;
    logic signed [SMP_W-1:0] right_in;
    logic [REQ_W-1:0]       request_count;
  } in_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic signed [SMP_W-1:0] left_out;
    logic signed [SMP_W-1:0] right_out;
    logic                   last;
    logic [CNT_W-1:0]       frames_consumed;
  } out_t;

  typedef struct packed {
    logic ld_in;
    logic do_op;
    logic single_emit;
    logic frame_start;
    logic rd_take;
    logic div_start;
    logic div_sel;
    logic div_take;
    logic frame_emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       pull_end;
    logic       frame_real;
    logic       need_fin;
    logic       need_fout;
    logic       last_frame;
    logic       div_done;
    logic       slot_free;
  } sts_t;

endpackage

FILE: sv/afw_ring.sv
// ----------------------------------------------------------------------------
// afw_ring: frame store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module afw_ring
  import afw_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [PTR_W-1:0]   waddr,
  input  logic [FRAME_W-1:0] wdata,
  input  logic               re,
  input  logic [PTR_W-1:0]   raddr,
  output logic [FRAME_W-1:0] rdata
);

  logic [FRAME_W-1:0] mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/afw_div.sv
// ----------------------------------------------------------------------------
// afw_div: stereo gain unit
// Scale both samples by gain/len, truncated toward zero; one quotient bit
// per cycle after a registered multiply.
// ----------------------------------------------------------------------------
module afw_div
  import afw_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [REQ_W-1:0]        gain,
  input  logic [REQ_W-1:0]        len,
  input  logic signed [SMP_W-1:0] a_left,
  input  logic signed [SMP_W-1:0] a_right,
  output logic                    done,
  output logic signed [SMP_W-1:0] q_left,
  output logic signed [SMP_W-1:0] q_right
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LOAD = 2'd1;
  localparam logic [1:0] PH_RUN  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic [1:0]              phase;
  logic [STEP_W-1:0]       cnt;
  logic [REQ_W-1:0]        dvs;
  logic signed [MUL_W-1:0] prod [2];
  logic [MAG_W-1:0]        mag  [2];
  logic [REQ_W-1:0]        rem  [2];
  logic                    neg  [2];
  logic [REQ_W:0]          trial [2];
  logic [MUL_W-1:0]        absp [2];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      trial[j] = {rem[j], mag[j][MAG_W-1]};
      absp[j]  = prod[j][MUL_W-1] ? MUL_W'(-prod[j]) : MUL_W'(prod[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      case (phase)
        PH_IDLE: if (start) phase <= PH_LOAD;
        PH_LOAD: phase <= PH_RUN;
        PH_RUN:  if (cnt == STEP_W'(MAG_W - 1)) phase <= PH_DONE;
        PH_DONE: phase <= PH_IDLE;
        default: phase <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (phase == PH_IDLE && start) begin
      prod[0] <= MUL_W'(a_left * $signed({1'b0, gain}));
      prod[1] <= MUL_W'(a_right * $signed({1'b0, gain}));
      dvs     <= len;
    end
    if (phase == PH_LOAD) begin
      cnt <= '0;
      for (int j = 0; j < 2; j++) begin
        neg[j] <= prod[j][MUL_W-1];
        mag[j] <= absp[j][MAG_W-1:0];
        rem[j] <= '0;
      end
    end
    if (phase == PH_RUN) begin
      cnt <= cnt + 1'b1;
      for (int j = 0; j < 2; j++) begin
        if (trial[j] >= {1'b0, dvs}) begin
          rem[j] <= REQ_W'(trial[j] - {1'b0, dvs});
          mag[j] <= {mag[j][MAG_W-2:0], 1'b1};
        end else begin
          rem[j] <= trial[j][REQ_W-1:0];
          mag[j] <= {mag[j][MAG_W-2:0], 1'b0};
        end
      end
    end
  end

  assign done    = (phase == PH_DONE);
  assign q_left  = neg[0] ? -$signed(mag[0][SMP_W-1:0]) : $signed(mag[0][SMP_W-1:0]);
  assign q_right = neg[1] ? -$signed(mag[1][SMP_W-1:0]) : $signed(mag[1][SMP_W-1:0]);

endmodule

FILE: sv/afw_ctrl.sv
// ----------------------------------------------------------------------------
// afw_ctrl: item sequencer
// Steps each word through decode, ring access, fades and result delivery.
// ----------------------------------------------------------------------------
module afw_ctrl
  import afw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_SINGLE = 4'd2;
  localparam logic [3:0] S_FRAME  = 4'd3;
  localparam logic [3:0] S_RDW    = 4'd4;
  localparam logic [3:0] S_FIN    = 4'd5;
  localparam logic [3:0] S_FIN_W  = 4'd6;
  localparam logic [3:0] S_FOUT   = 4'd7;
  localparam logic [3:0] S_FOUT_W = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  logic [3:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.do_op = 1'b1;
        if (sts.op == OP_PUSH) begin
          state_next = S_SINGLE;
        end else if (sts.op == OP_PULL) begin
          state_next = sts.pull_end ? S_SINGLE : S_FRAME;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SINGLE: begin
        if (sts.slot_free) begin
          cmd.single_emit = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_FRAME: begin
        cmd.frame_start = 1'b1;
        state_next      = sts.frame_real ? S_RDW : S_EMIT;
      end
      S_RDW: begin
        cmd.rd_take = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        if (sts.need_fin) begin
          cmd.div_start = 1'b1;
          state_next    = S_FIN_W;
        end else begin
          state_next = S_FOUT;
        end
      end
      S_FIN_W: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = S_FOUT;
        end
      end
      S_FOUT: begin
        if (sts.need_fout) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_next    = S_FOUT_W;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_FOUT_W: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.slot_free) begin
          cmd.frame_emit = 1'b1;
          state_next     = sts.last_frame ? S_IDLE : S_FRAME;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/afw_datapath.sv
// ----------------------------------------------------------------------------
// afw_datapath: ring pointers, playback flags, gain unit and result register
// Acts on controller commands and reports status back.
// ----------------------------------------------------------------------------
module afw_datapath
  import afw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  in_t              in_data,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_data,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data
);

  in_t                     in_q;
  logic [PTR_W-1:0]        rp, wp, rd_addr;
  logic                    full, buffering, silent_before, src_done;
  logic [CNT_W-1:0]        consumed;
  logic [THR_W-1:0]        thr;
  logic [REQ_W-1:0]        req, n, flen, k;
  logic                    fade_in, fade_out;
  logic                    end_q;
  logic signed [SMP_W-1:0] smp_l, smp_r;
  logic [FRAME_W-1:0]      rdata;

  logic [REQ_W-1:0]        req_c, n_c, flen_c, gain_c;
  logic [THR_W-1:0]        thr_c;
  logic [AVAIL_W-1:0]      avail_c;
  logic                    silent_c, short_c, ring_we, ring_re;
  logic                    div_done;
  logic signed [SMP_W-1:0] q_l, q_r;

  always_comb begin
    if (in_q.request_count == '0) begin
      req_c = REQ_W'(1);
    end else if (in_q.request_count > REQ_W'(MAX_REQUEST)) begin
      req_c = REQ_W'(MAX_REQUEST);
    end else begin
      req_c = in_q.request_count;
    end
    if (thr == '0) begin
      thr_c = THR_W'(1);
    end else if (thr > THR_W'(RING_DEPTH)) begin
      thr_c = THR_W'(RING_DEPTH);
    end else begin
      thr_c = thr;
    end
    avail_c  = full ? AVAIL_W'(RING_DEPTH) : {1'b0, PTR_W'(wp - rp)};
    silent_c = (buffering && !src_done && avail_c < AVAIL_W'(thr_c)) || avail_c == '0;
    n_c      = (avail_c < AVAIL_W'(req_c)) ? avail_c[REQ_W-1:0] : req_c;
    flen_c   = (n_c < REQ_W'(FADE_MAX)) ? n_c : REQ_W'(FADE_MAX);
    short_c  = n_c < req_c;
    gain_c   = cmd.div_sel ? REQ_W'(n - 1'b1 - k) : k;
  end

  assign ring_we = cmd.single_emit && in_q.operation == OP_PUSH && !full;
  assign ring_re = cmd.frame_start && (k < n);

  afw_ring u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wp),
    .wdata ({in_q.right_in, in_q.left_in}),
    .re    (ring_re),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  afw_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .gain    (gain_c),
    .len     (flen),
    .a_left  (smp_l),
    .a_right (smp_r),
    .done    (div_done),
    .q_left  (q_l),
    .q_right (q_r)
  );

  assign sts.op         = in_q.operation;
  assign sts.pull_end   = avail_c == '0 && src_done;
  assign sts.frame_real = k < n;
  assign sts.need_fin   = fade_in && k < flen;
  assign sts.need_fout  = fade_out && k >= REQ_W'(n - flen);
  assign sts.last_frame = k == REQ_W'(req - 1'b1);
  assign sts.div_done   = div_done;
  assign sts.slot_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rp            <= '0;
      wp            <= '0;
      full          <= 1'b0;
      buffering     <= 1'b1;
      silent_before <= 1'b0;
      src_done      <= 1'b0;
      consumed      <= '0;
      thr           <= THR_RESET;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr <= cfg_data;
      end
      if (cmd.do_op && in_q.operation == OP_END) begin
        src_done <= 1'b1;
      end
      if (cmd.do_op && in_q.operation == OP_PULL && !sts.pull_end) begin
        if (silent_c) begin
          if (avail_c == '0) begin
            buffering <= 1'b1;
          end
          silent_before <= 1'b1;
        end else begin
          rp            <= PTR_W'(rp + PTR_W'(n_c));
          consumed      <= consumed + CNT_W'(n_c);
          full          <= 1'b0;
          silent_before <= short_c;
          buffering     <= short_c && !src_done;
        end
      end
      if (ring_we) begin
        wp <= wp + 1'b1;
        if (PTR_W'(wp + 1'b1) == rp) begin
          full <= 1'b1;
        end
      end
      if (cmd.single_emit || cmd.frame_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      in_q <= in_data;
    end
    if (cmd.do_op) begin
      req      <= req_c;
      rd_addr  <= rp;
      k        <= '0;
      end_q    <= sts.pull_end;
      n        <= silent_c ? '0 : n_c;
      flen     <= flen_c;
      fade_in  <= silent_before;
      fade_out <= short_c;
    end
    if (cmd.frame_start) begin
      if (ring_re) begin
        rd_addr <= rd_addr + 1'b1;
      end else begin
        smp_l <= '0;
        smp_r <= '0;
      end
    end
    if (cmd.rd_take) begin
      smp_l <= $signed(rdata[SMP_W-1:0]);
      smp_r <= $signed(rdata[FRAME_W-1:SMP_W]);
    end
    if (cmd.div_take) begin
      smp_l <= q_l;
      smp_r <= q_r;
    end
    if (cmd.single_emit) begin
      if (in_q.operation == OP_PUSH) begin
        out_data.kind <= full ? KIND_PUSH_FULL : KIND_PUSH_OK;
      end else begin
        out_data.kind <= end_q ? KIND_EOS : KIND_FRAME;
      end
      out_data.left_out        <= '0;
      out_data.right_out       <= '0;
      out_data.last            <= 1'b1;
      out_data.frames_consumed <= consumed;
    end
    if (cmd.frame_emit) begin
      out_data.kind            <= KIND_FRAME;
      out_data.left_out        <= smp_l;
      out_data.right_out       <= smp_r;
      out_data.last            <= sts.last_frame;
      out_data.frames_consumed <= consumed;
      k                        <= k + 1'b1;
    end
  end

endmodule

FILE: sv/audio_prefetch_fifo_with_fades.sv
// Push and end-of-stream results pass the decode and single-result states into the
// result register. Pull: each frame is read from the ring, then faded through the shared
// bit-serial gain unit where needed, then emitted; silent frames skip the ring read.
// One word is in work at a time; the next is taken once the last result is queued.
// Reset (synchronous, rst high): ring empty, buffering on, threshold 4096,
// frame counter zero; ring contents stay undefined until written.
// ----------------------------------------------------------------------------
// audio_prefetch_fifo_with_fades: stereo prefetch ring with fades
// Buffers pushed frames and plays them out on pull requests with fade-in
// after silence and fade-out on short reads.
// ----------------------------------------------------------------------------
module audio_prefetch_fifo_with_fades
  import afw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  afw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  afw_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("word taken while another is in work");

  a_non_frame_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind != KIND_FRAME |-> out_data.last && out_data.left_out == '0)
    else $error("status result not final or not silent");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.single_emit || cmd.frame_emit |-> !out_valid || out_ready)
    else $error("result register overwritten");
`endif

endmodule
